>>> rtl/odqsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odqsd_pkg
// Shared types, constants and arithmetic helpers of the DQPSK soft demodulator.
// ----------------------------------------------------------------------------
package odqsd_pkg;

  localparam int MAX_FFT_SIZE_DEF = 2048;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int FFT_SIZE_W = 12;
  localparam int CARRIER_W  = 11;
  localparam int OFFSET_W   = 12;
  localparam int SOFT_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [FFT_SIZE_W-1:0] FFT_SIZE_RST = 12'd2048;
  localparam logic [CARRIER_W-1:0]  ACT_CAR_RST  = 11'd1536;

  // normalised part magnitudes, sum of squares, restoring search words
  localparam int PART_W = 16;
  localparam int SQ_W   = 2 * PART_W + 1;
  localparam int QS_W   = SQ_W + PART_W;
  localparam int REM_W  = 67;
  localparam int Q_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FFT_SIZE     = 2'd0,
    CFG_ACT_CARRIERS = 2'd1
  } cfg_idx_t;

  // per-word side information travelling with the pipeline
  typedef struct packed {
    logic [CARRIER_W-1:0] carrier;
    logic                 last;
    logic                 neg_re;
    logic                 neg_im;
    logic                 zero;
  } side_t;

  // one lane of the bit-per-stage quotient search
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QS_W-1:0]   qs;
    logic [Q_BITS-1:0] q;
  } lane_t;

  // try bit j of q: (q+2^j)^2 s = q^2 s + 2^(j+1) q s + 2^(2j) s
  function automatic lane_t norm_step(lane_t l, logic [SQ_W-1:0] s, int j);
    logic [REM_W-1:0] t;
    lane_t            o;
    t = (REM_W'(l.qs) << (j + 1)) + (REM_W'(s) << (2 * j));
    o = l;
    if (t <= l.rem) begin
      o.rem  = l.rem - t;
      o.qs   = l.qs + (QS_W'(s) << j);
      o.q[j] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [SOFT_W-1:0] to_soft(logic neg, logic [Q_BITS-1:0] q);
    logic [SOFT_W-1:0] r;
    if (neg) begin
      r = SOFT_W'(-q);
    end else if (q > 16'd32767) begin
      r = 16'd32767;
    end else begin
      r = q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ofdm_dqpsk_soft_demodulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofdm_dqpsk_soft_demodulator_unit
// Differential DQPSK soft demodulator, one FFT bin per clock when not stalled.
// ----------------------------------------------------------------------------
// Takes one bin word per clock while in_stall is low. Reference-mode words
// only overwrite the per-bin phase reference; data-mode words give one
// result word holding the product x*conj(ref) scaled to unit magnitude in
// Q1.15 (zero product gives zero). The pipeline is 23 register stages deep;
// one word is taken every clock unless stalled, and stalls only back up
// through stages that are full. Depth is set by the 16-stage quotient search
// (one soft bit per stage per part). After reset the reference RAM is zeroed
// by a sweep over every address of the RAM, during which in_stall is high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ofdm_dqpsk_soft_demodulator_unit #(
  parameter int MAX_FFT_SIZE = odqsd_pkg::MAX_FFT_SIZE_DEF,
  parameter int SAMPLE_WIDTH = odqsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [odqsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [odqsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input words
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_mode,
  input  wire logic [odqsd_pkg::CARRIER_W-1:0]     in_carrier_index,
  input  wire logic signed [odqsd_pkg::OFFSET_W-1:0] in_bin_offset,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample_real,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample_imag,
  // result words
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [odqsd_pkg::CARRIER_W-1:0]          out_carrier,
  output logic signed [odqsd_pkg::SOFT_W-1:0]      out_soft_real,
  output logic signed [odqsd_pkg::SOFT_W-1:0]      out_soft_imag,
  output logic                                     out_last
);
  import odqsd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_FFT_SIZE);
  localparam int SW     = SAMPLE_WIDTH;
  localparam int PW     = 2 * SW;      // product width
  localparam int MW     = 2 * SW + 1;  // sum of two products
  // stage map: 0 RAM read, 1 multiply, 2 sign/magnitude, 3-4 scale-down,
  // 5 squares, 6..21 quotient bits, 22 output register
  localparam int ST_SQ  = 5;
  localparam int NST    = ST_SQ + Q_BITS + 2;
  localparam int ST_OUT = NST - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FFT_SIZE_W-1:0] fft_size_r;
  logic [CARRIER_W-1:0]  act_car_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_size_r <= FFT_SIZE_RST;
      act_car_r  <= ACT_CAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FFT_SIZE:     fft_size_r <= cfg_data[FFT_SIZE_W-1:0];
        CFG_ACT_CARRIERS: act_car_r  <= cfg_data[CARRIER_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  logic           clr_busy_r;
  logic           acc;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = clr_busy_r || !en[0];
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= acc && in_mode;  // reference words give no result
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Bin address: negative offsets wrap by fft_size, then mod RAM depth
  // --------------------------------------------------------------------------
  logic signed [OFFSET_W+1:0] bin_sum;
  logic [ADDR_W-1:0]          bin_idx;

  assign bin_sum = {{2{in_bin_offset[OFFSET_W-1]}}, in_bin_offset}
                 + (in_bin_offset[OFFSET_W-1] ? {2'b00, fft_size_r} : '0);
  assign bin_idx = bin_sum[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // Phase reference RAM; read-first, so back-to-back words on one bin see
  // the previous word's sample
  // --------------------------------------------------------------------------
  logic [PW-1:0]     ref_mem [MAX_FFT_SIZE];
  logic [ADDR_W-1:0] clr_addr_r;
  logic [PW-1:0]     ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(MAX_FFT_SIZE - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      ref_mem[clr_addr_r] <= '0;
    end else if (acc) begin
      ref_mem[bin_idx] <= {in_sample_real, in_sample_imag};
    end
    if (en[0]) begin
      ref_r <= ref_mem[bin_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Side band
  // --------------------------------------------------------------------------
  side_t side_r   [NST];
  side_t side_nxt [NST];

  // --------------------------------------------------------------------------
  // Stage 0 payload
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] x_re_r, x_im_r;
  logic                 last_in;

  assign last_in = (act_car_r != '0)
                && (({1'b0, in_carrier_index} + 12'd1) == {1'b0, act_car_r});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_re_r <= in_sample_real;
      x_im_r <= in_sample_imag;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: four products of x * conj(ref)
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] r_re, r_im;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;

  assign r_re = signed'(ref_r[PW-1:SW]);
  assign r_im = signed'(ref_r[SW-1:0]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_rr_r <= x_re_r * r_re;
      p_ii_r <= x_im_r * r_im;
      p_ir_r <= x_im_r * r_re;
      p_ri_r <= x_re_r * r_im;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sums to sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] sum_re, sum_im;
  logic [MW-1:0]        mag_re_r, mag_im_r;

  assign sum_re = MW'(p_rr_r) + MW'(p_ii_r);
  assign sum_im = MW'(p_ir_r) - MW'(p_ri_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag_re_r <= sum_re[MW-1] ? MW'(-sum_re) : MW'(sum_re);
      mag_im_r <= sum_im[MW-1] ? MW'(-sum_im) : MW'(sum_im);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3-4: shift both parts right together until both fit 16 bits,
  // binary steps 32/16/8 then 4/2/1
  // --------------------------------------------------------------------------
  logic [MW-1:0] sh1_re, sh1_im, sh2_re, sh2_im;
  logic [MW-1:0] nrm_re_r, nrm_im_r;
  logic [MW-1:0] sh4_re, sh4_im, sh5_re, sh5_im;
  logic [MW-1:0] sh6_re, sh6_im, sh7_re, sh7_im;
  logic [PART_W-1:0] a_r, b_r;

  always_comb begin
    sh1_re = mag_re_r;
    sh1_im = mag_im_r;
    if (((sh1_re | sh1_im) >> 47) != '0) begin
      sh1_re = sh1_re >> 32;
      sh1_im = sh1_im >> 32;
    end
    sh2_re = sh1_re;
    sh2_im = sh1_im;
    if (((sh2_re | sh2_im) >> 31) != '0) begin
      sh2_re = sh2_re >> 16;
      sh2_im = sh2_im >> 16;
    end
    if (((sh2_re | sh2_im) >> 23) != '0) begin
      sh2_re = sh2_re >> 8;
      sh2_im = sh2_im >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nrm_re_r <= sh2_re;
      nrm_im_r <= sh2_im;
    end
  end

  always_comb begin
    sh4_re = nrm_re_r;
    sh4_im = nrm_im_r;
    sh5_re = sh4_re;
    sh5_im = sh4_im;
    if (((sh4_re | sh4_im) >> 19) != '0) begin
      sh5_re = sh4_re >> 4;
      sh5_im = sh4_im >> 4;
    end
    sh6_re = sh5_re;
    sh6_im = sh5_im;
    if (((sh5_re | sh5_im) >> 17) != '0) begin
      sh6_re = sh5_re >> 2;
      sh6_im = sh5_im >> 2;
    end
    sh7_re = sh6_re;
    sh7_im = sh6_im;
    if (((sh6_re | sh6_im) >> 16) != '0) begin
      sh7_re = sh6_re >> 1;
      sh7_im = sh6_im >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a_r <= sh7_re[PART_W-1:0];
      b_r <= sh7_im[PART_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: s = a^2 + b^2, search limits 2^30 a^2 and 2^30 b^2
  // Stages 6..21: one quotient bit per stage, msb first, both parts
  // --------------------------------------------------------------------------
  logic [2*PART_W-1:0] a_sq, b_sq;
  lane_t               lre_r [Q_BITS+1];
  lane_t               lim_r [Q_BITS+1];
  logic [SQ_W-1:0]     s_r   [Q_BITS+1];

  assign a_sq = a_r * a_r;
  assign b_sq = b_r * b_r;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      s_r[0]       <= SQ_W'(a_sq) + SQ_W'(b_sq);
      lre_r[0].rem <= REM_W'(a_sq) << 30;
      lre_r[0].qs  <= '0;
      lre_r[0].q   <= '0;
      lim_r[0].rem <= REM_W'(b_sq) << 30;
      lim_r[0].qs  <= '0;
      lim_r[0].q   <= '0;
    end
  end

  for (genvar g = 1; g <= Q_BITS; g++) begin : g_qbit
    always_ff @(posedge clk) begin
      if (en[ST_SQ+g]) begin
        s_r[g]   <= s_r[g-1];
        lre_r[g] <= norm_step(lre_r[g-1], s_r[g-1], Q_BITS - g);
        lim_r[g] <= norm_step(lim_r[g-1], s_r[g-1], Q_BITS - g);
      end
    end
  end

  // side band updates: signs at stage 2, zero flag at stage 5
  always_comb begin
    side_nxt[0].carrier = in_carrier_index;
    side_nxt[0].last    = last_in;
    side_nxt[0].neg_re  = 1'b0;
    side_nxt[0].neg_im  = 1'b0;
    side_nxt[0].zero    = 1'b0;
    for (int k = 1; k < NST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[2].neg_re    = sum_re[MW-1];
    side_nxt[2].neg_im    = sum_im[MW-1];
    side_nxt[ST_SQ].zero  = (a_r == '0) && (b_r == '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply signs, saturate +1.0, zero product gives zero
  // --------------------------------------------------------------------------
  logic [SOFT_W-1:0] soft_re_r, soft_im_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (side_r[ST_OUT-1].zero) begin
        soft_re_r <= '0;
        soft_im_r <= '0;
      end else begin
        soft_re_r <= to_soft(side_r[ST_OUT-1].neg_re, lre_r[Q_BITS].q);
        soft_im_r <= to_soft(side_r[ST_OUT-1].neg_im, lim_r[Q_BITS].q);
      end
    end
  end

  assign out_valid     = vld_r[ST_OUT];
  assign out_carrier   = side_r[ST_OUT].carrier;
  assign out_last      = side_r[ST_OUT].last;
  assign out_soft_real = signed'(soft_re_r);
  assign out_soft_imag = signed'(soft_im_r);

endmodule
`default_nettype wire
